>>> hw/rtl/bba_pkg.sv
// bba_pkg: sizes, register indexes and action codes of the bitmap block allocator
// no dependencies; imported by bitmap_block_allocator_unit
`default_nettype none

package bba_pkg;

    // map size and the fixed field widths
    localparam int MAX_BLOCKS = 4096;
    localparam int FA_W       = 12;   // first_allocatable
    localparam int BC_W       = 13;   // block_count
    localparam int BLK_OUT_W  = 12;   // target_block / granted_block
    localparam int CFG_DATA_W = BC_W;
    localparam int CFG_IDX_W  = 1;

    // bitmap word layout in the ram
    localparam int WORD_W  = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
    localparam int IDX_W   = $clog2(WORD_W);
    localparam int WORDS   = MAX_BLOCKS / WORD_W;
    localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int EFF_W   = (BLK_W + 1 > BC_W) ? BLK_W + 1 : BC_W;
    localparam int GNT_X_W = (BLK_W > BLK_OUT_W) ? BLK_W : BLK_OUT_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ALLOC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/bba_ram.sv
// bba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the allocation bitmap
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_block_allocator_unit.sv
// bitmap_block_allocator_unit: first-fit block allocator over a used-block bitmap
// depends on bba_pkg and bba_ram
//
// A request is taken when start is high and busy is low; its one result shows on the
// o_ result ports for a single cycle with o_done high and cannot be held off. The
// bitmap lives in a ram of 128 words of 32 bits. An allocate reads one word per cycle
// from the word holding first_allocatable and picks the lowest free bit with a priority
// encoder; busy stays high while it scans, and its result shows as busy falls. A free
// reads one word and rewrites it if the block was in use: busy is high one cycle. A free
// outside the block count, or an allocate whose first_allocatable is at or past it,
// answers in the next cycle with busy staying low. After reset a clearing pass writes
// every ram word to zero with busy high; configuration writes are taken at any time.
`default_nettype none

module bitmap_block_allocator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic [bba_pkg::BLK_OUT_W-1:0]     i_target_block,
    output logic                                   o_done,
    output logic      [bba_pkg::BLK_OUT_W-1:0]     o_granted_block,
    output logic                                   o_no_free_block,
    output logic                                   o_was_in_use
);

    import bba_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]    r_bit, n_bit;
    logic                r_done, n_done;
    logic [BLK_OUT_W-1:0] r_granted, n_granted;
    logic                r_no_free, n_no_free;
    logic                r_was_used, n_was_used;

    logic [FA_W-1:0]     r_first_alloc;
    logic [BC_W-1:0]     r_block_count;

    // ram ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // derived scan bounds
    logic [EFF_W-1:0]    eff_count;
    logic [EFF_W-1:0]    eff_m1;
    logic [BLK_W-1:0]    first_blk;
    logic [BLK_W-1:0]    last_blk;
    logic [BLK_W-1:0]    tgt_blk;
    logic [ADDR_W-1:0]   first_word;
    logic [ADDR_W-1:0]   last_word;
    logic                start_past_end;
    logic                tgt_out_of_range;

    // word scan
    logic [WORD_W-1:0]   lo_mask;
    logic [WORD_W-1:0]   hi_mask;
    logic [WORD_W-1:0]   cand;
    logic                cand_any;
    logic [IDX_W-1:0]    pe_idx;
    logic [BLK_W-1:0]    found_blk;
    logic [GNT_X_W-1:0]  found_ext;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .AW    (ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_alloc <= FA_W'(1);
            r_block_count <= BC_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_ALLOC: r_first_alloc <= i_cfg_data[FA_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                default:         r_block_count <= r_block_count;
            endcase
        end
    end

    // a count above the map is clamped to the map size
    assign eff_count = (EFF_W'(r_block_count) > EFF_W'(MAX_BLOCKS)) ?
                       EFF_W'(MAX_BLOCKS) : EFF_W'(r_block_count);
    assign eff_m1           = eff_count - EFF_W'(1);
    assign start_past_end   = EFF_W'(r_first_alloc) >= eff_count;
    assign tgt_out_of_range = EFF_W'(i_target_block) >= eff_count;
    assign first_blk        = BLK_W'(r_first_alloc);
    assign last_blk         = BLK_W'(eff_m1);
    assign tgt_blk          = BLK_W'(i_target_block);
    assign first_word       = ADDR_W'(first_blk >> IDX_W);
    assign last_word        = ADDR_W'(last_blk >> IDX_W);

    // only bits inside [first_allocatable, count) of the current word may be taken
    assign lo_mask = (r_cur == first_word) ?
                     ({WORD_W{1'b1}} << first_blk[IDX_W-1:0]) : {WORD_W{1'b1}};
    assign hi_mask = (r_cur == last_word) ?
                     ({WORD_W{1'b1}} >> (IDX_W'(WORD_W - 1) - last_blk[IDX_W-1:0])) :
                     {WORD_W{1'b1}};
    assign cand     = ~ram_rdata & lo_mask & hi_mask;
    assign cand_any = |cand;

    // lowest free bit
    always_comb begin
        pe_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pe_idx = IDX_W'(i);
            end
        end
    end

    assign found_blk = (BLK_W'(r_cur) << IDX_W) | BLK_W'(pe_idx);
    assign found_ext = GNT_X_W'(found_blk);

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_bit      = r_bit;
        n_done     = 1'b0;
        n_granted  = '0;
        n_no_free  = 1'b0;
        n_was_used = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_cur;
        ram_wdata  = '0;
        ram_raddr  = r_cur + ADDR_W'(1);

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_cur  = r_cur + ADDR_W'(1);
                if (r_cur == ADDR_W'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_action == ACT_ALLOC) begin
                        if (start_past_end) begin
                            n_done    = 1'b1;
                            n_no_free = 1'b1;
                        end else begin
                            ram_raddr = first_word;
                            n_cur     = first_word;
                            n_state   = ST_ALLOC;
                        end
                    end else begin
                        if (tgt_out_of_range) begin
                            n_done = 1'b1;
                        end else begin
                            ram_raddr = ADDR_W'(tgt_blk >> IDX_W);
                            n_cur     = ADDR_W'(tgt_blk >> IDX_W);
                            n_bit     = tgt_blk[IDX_W-1:0];
                            n_state   = ST_FREE;
                        end
                    end
                end
            end
            ST_ALLOC: begin
                // ram_rdata holds word r_cur; the read of r_cur + 1 goes out meanwhile
                if (cand_any) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (WORD_W'(1) << pe_idx);
                    n_done    = 1'b1;
                    n_granted = found_ext[BLK_OUT_W-1:0];
                    n_state   = ST_IDLE;
                end else if (r_cur == last_word) begin
                    n_done    = 1'b1;
                    n_no_free = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_cur = r_cur + ADDR_W'(1);
                end
            end
            ST_FREE: begin
                if (ram_rdata[r_bit]) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~(WORD_W'(1) << r_bit);
                    n_was_used = 1'b1;
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cur   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_done  <= n_done;
        end
        r_bit      <= n_bit;
        r_granted  <= n_granted;
        r_no_free  <= n_no_free;
        r_was_used <= n_was_used;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_granted_block = r_granted;
    assign o_no_free_block = r_no_free;
    assign o_was_in_use    = r_was_used;

`ifndef SYNTHESIS
    // a result is only ever issued on the way back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // every accepted item either answers next cycle or starts ram work
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted item lost");

    // the bitmap is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("bitmap write while idle");

    // a failed allocate carries no block and no free status
    a_no_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_no_free_block) |-> (o_granted_block == '0 && !o_was_in_use))
        else $error("no-free result carries data");

    // a scan never runs past the last word of the count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |-> (r_cur <= last_word))
        else $error("allocate scan past block count");
`endif

endmodule

`default_nettype wire
